/* src/npst_pkg.sv */
// npst_pkg: field widths, operation and page condition codes, and the
// shared structs of the NAND page state tracker. No dependencies.
package npst_pkg;

  localparam int OP_W      = 3;
  localparam int BLK_IDX_W = 8;
  localparam int PG_IDX_W  = 6;
  localparam int TAG_W     = 32;
  localparam int VCNT_W    = 7;
  localparam int ERASE_W   = 32;
  localparam int TOT_W     = 64;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_INVAL = 3'd2,
    OP_ERASE = 3'd3,
    OP_STATS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    COND_FREE  = 2'd0,
    COND_VALID = 2'd1,
    COND_STALE = 2'd2
  } cond_t;

  // per-block counts, kept at the top of each block row
  typedef struct packed {
    logic [ERASE_W-1:0] erases;
    logic [VCNT_W-1:0]  valid_pages;
  } blk_cnt_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic er;
    logic inv;
  } stat_inc_t;

  typedef struct packed {
    logic [TOT_W-1:0] reads;
    logic [TOT_W-1:0] writes;
    logic [TOT_W-1:0] erases;
    logic [TOT_W-1:0] invals;
  } stat_tot_t;

endpackage

/* src/npst_if.sv */
// npst_if: request and result channel interfaces (valid/ready).
// Depends on npst_pkg for field widths.
interface npst_in_if;
  logic                               valid;
  logic                               ready;
  logic [npst_pkg::OP_W-1:0]          operation;
  logic [npst_pkg::BLK_IDX_W-1:0]     block_index;
  logic [npst_pkg::PG_IDX_W-1:0]      page_index;
  logic [npst_pkg::TAG_W-1:0]         sector_tag;

  modport source (output valid, operation, block_index, page_index, sector_tag,
                  input ready);
  modport sink   (input valid, operation, block_index, page_index, sector_tag,
                  output ready);
endinterface

interface npst_out_if;
  logic                               valid;
  logic                               ready;
  logic [npst_pkg::TAG_W-1:0]         read_tag;
  logic                               page_hit;
  logic                               write_refused;
  logic [npst_pkg::VCNT_W-1:0]        block_valid_pages;
  logic [npst_pkg::ERASE_W-1:0]       block_erases;
  logic [npst_pkg::TOT_W-1:0]         reads_total;
  logic [npst_pkg::TOT_W-1:0]         writes_total;
  logic [npst_pkg::TOT_W-1:0]         erases_total;
  logic [npst_pkg::TOT_W-1:0]         invalidations_total;

  modport source (output valid, read_tag, page_hit, write_refused, block_valid_pages,
                  block_erases, reads_total, writes_total, erases_total,
                  invalidations_total,
                  input ready);
  modport sink   (input valid, read_tag, page_hit, write_refused, block_valid_pages,
                  block_erases, reads_total, writes_total, erases_total,
                  invalidations_total,
                  output ready);
endinterface

/* src/nand_page_state_tracker.sv */
// nand_page_state_tracker: top level. Request decode, read-modify-write of
// block rows and tags, result register. Uses npst_pkg, npst_if, npst_block_store,
// npst_tag_store and npst_stats.
//
// Usage:
//   in_ch  (sink)  : one request per transfer - operation, block, page, tag.
//   out_ch (source): exactly one result per request, in request order.
//   Sequence: at transfer the block row memory and the tag memory are read
//   (synchronous, registered read); then the request modifies and writes
//   them back as its result is registered. The next request is only taken
//   once the write-back is done, so same-entry accesses never overlap.
//   Erase frees a whole block in one row write: a block's page conditions
//   and counts live in one row of the block memory.
//   Reset: per-row valid bits (one per block) clear at once, so every page
//   reads free and every count zero; no clearing pass, ready straight away.
//   Tag memory has no reset; a tag is only ever shown for a valid page.
//   Stall: a result may wait in the output register while the next request
//   is transferred; that request then holds its write-back until the
//   register empties. in_ch.ready is low while a request is in progress.
module nand_page_state_tracker #(
  parameter int BLOCK_COUNT     = 256,
  parameter int PAGES_PER_BLOCK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  npst_in_if.sink     in_ch,
  npst_out_if.source  out_ch
);

  // only blocks/pages reachable by the index fields need storage
  localparam int BLK_SPAN = 1 << npst_pkg::BLK_IDX_W;
  localparam int PG_SPAN  = 1 << npst_pkg::PG_IDX_W;
  localparam int BLK_USED = (BLOCK_COUNT < BLK_SPAN) ? BLOCK_COUNT : BLK_SPAN;
  localparam int PG_USED  = (PAGES_PER_BLOCK < PG_SPAN) ? PAGES_PER_BLOCK : PG_SPAN;
  localparam int BLK_AW   = (BLK_USED > 1) ? $clog2(BLK_USED) : 1;
  localparam int PG_AW    = (PG_USED > 1) ? $clog2(PG_USED) : 1;
  localparam int TAG_DEPTH = BLK_USED * PG_USED;
  localparam int TAG_AW   = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int COND_W   = 2 * PG_USED;
  localparam int CNT_W    = $bits(npst_pkg::blk_cnt_t);
  localparam int ROW_W    = COND_W + CNT_W;
  localparam logic [16:0] BLK_LIM = 17'(BLOCK_COUNT);
  localparam logic [10:0] PG_LIM  = 11'(PAGES_PER_BLOCK);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;

  // ---- request decode at transfer ----
  logic              in_xfer;
  logic              blk_ok, pg_ok;
  logic [BLK_AW-1:0] blk_a;
  logic [PG_AW-1:0]  pg_a;
  logic [TAG_AW-1:0] tag_a;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    blk_ok = {9'd0, in_ch.block_index} < BLK_LIM;
    pg_ok  = blk_ok && ({5'd0, in_ch.page_index} < PG_LIM);
    blk_a  = blk_ok ? BLK_AW'(in_ch.block_index) : '0;
    pg_a   = pg_ok ? PG_AW'(in_ch.page_index) : '0;
    // constant multiply: page slot = block * pages + page
    tag_a  = pg_ok ? TAG_AW'(TAG_AW'(blk_a) * TAG_AW'(PG_USED) + TAG_AW'(pg_a)) : '0;
  end

  // ---- request registers ----
  logic [npst_pkg::OP_W-1:0]  op_r;
  logic                       blk_ok_r, pg_ok_r;
  logic [BLK_AW-1:0]          blk_a_r;
  logic [PG_AW-1:0]           pg_a_r;
  logic [TAG_AW-1:0]          tag_a_r;
  logic [npst_pkg::TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.operation;
      blk_ok_r <= blk_ok;
      pg_ok_r  <= pg_ok;
      blk_a_r  <= blk_a;
      pg_a_r   <= pg_a;
      tag_a_r  <= tag_a;
      tag_r    <= in_ch.sector_tag;
    end
  end

  // ---- memories ----
  logic [ROW_W-1:0]           row_rd, row_wr;
  logic                       row_we;
  logic [npst_pkg::TAG_W-1:0] tag_rd;
  logic                       tag_we;
  logic                       fire;

  npst_block_store #(
    .DEPTH (BLK_USED),
    .ROW_W (ROW_W)
  ) u_blk (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (blk_a),
    .rd_row  (row_rd),
    .wr_en   (fire && row_we),
    .wr_addr (blk_a_r),
    .wr_row  (row_wr)
  );

  npst_tag_store #(
    .DEPTH (TAG_DEPTH)
  ) u_tag (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (tag_a),
    .rd_tag  (tag_rd),
    .wr_en   (fire && tag_we),
    .wr_addr (tag_a_r),
    .wr_tag  (tag_r)
  );

  // ---- modify ----
  npst_pkg::blk_cnt_t  cnt_old, cnt_new;
  npst_pkg::cond_t     cond;
  npst_pkg::stat_inc_t inc;
  npst_pkg::stat_tot_t tot_nxt;
  logic                hit, refused;
  logic [npst_pkg::TAG_W-1:0] rtag;

  assign cnt_old = npst_pkg::blk_cnt_t'(row_rd[ROW_W-1 -: CNT_W]);
  assign cond    = npst_pkg::cond_t'(row_rd[{pg_a_r, 1'b0} +: 2]);

  always_comb begin
    row_wr  = row_rd;
    cnt_new = cnt_old;
    row_we  = 1'b0;
    tag_we  = 1'b0;
    hit     = 1'b0;
    refused = 1'b0;
    rtag    = '1;
    inc     = '0;
    unique case (op_r)
      npst_pkg::OP_READ: begin
        inc.rd = 1'b1;
        if (pg_ok_r && cond == npst_pkg::COND_VALID) begin
          hit  = 1'b1;
          rtag = tag_rd;
        end
      end
      npst_pkg::OP_WRITE: begin
        inc.wr = 1'b1;
        if (pg_ok_r && cond == npst_pkg::COND_FREE) begin
          row_wr[{pg_a_r, 1'b0} +: 2] = npst_pkg::COND_VALID;
          cnt_new.valid_pages = cnt_old.valid_pages + npst_pkg::VCNT_W'(1);
          row_we = 1'b1;
          tag_we = 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
      npst_pkg::OP_INVAL: begin
        if (pg_ok_r && cond == npst_pkg::COND_VALID) begin
          row_wr[{pg_a_r, 1'b0} +: 2] = npst_pkg::COND_STALE;
          if (cnt_old.valid_pages != '0) begin
            cnt_new.valid_pages = cnt_old.valid_pages - npst_pkg::VCNT_W'(1);
          end
          row_we  = 1'b1;
          inc.inv = 1'b1;
        end
      end
      npst_pkg::OP_ERASE: begin
        inc.er = 1'b1;
        if (blk_ok_r) begin
          row_wr[COND_W-1:0]  = '0;
          cnt_new.valid_pages = '0;
          if (cnt_old.erases != '1) begin
            cnt_new.erases = cnt_old.erases + npst_pkg::ERASE_W'(1);
          end
          row_we = 1'b1;
        end
      end
      default: begin
        // statistics only, and unused codes
      end
    endcase
    row_wr[ROW_W-1 -: CNT_W] = cnt_new;
  end

  npst_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (fire),
    .inc     (inc),
    .tot_nxt (tot_nxt)
  );

  // ---- sequencing and result register ----
  logic                          out_valid_r;
  logic                          out_free;
  logic [npst_pkg::TAG_W-1:0]    out_tag_r;
  logic                          out_hit_r, out_ref_r;
  logic [npst_pkg::VCNT_W-1:0]   out_vcnt_r;
  logic [npst_pkg::ERASE_W-1:0]  out_ers_r;
  npst_pkg::stat_tot_t           out_tot_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = (state_r == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tag_r  <= rtag;
      out_hit_r  <= hit;
      out_ref_r  <= refused;
      out_vcnt_r <= blk_ok_r ? cnt_new.valid_pages : '0;
      out_ers_r  <= blk_ok_r ? cnt_new.erases : '0;
      out_tot_r  <= tot_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.read_tag            = out_tag_r;
  assign out_ch.page_hit            = out_hit_r;
  assign out_ch.write_refused       = out_ref_r;
  assign out_ch.block_valid_pages   = out_vcnt_r;
  assign out_ch.block_erases        = out_ers_r;
  assign out_ch.reads_total         = out_tot_r.reads;
  assign out_ch.writes_total        = out_tot_r.writes;
  assign out_ch.erases_total        = out_tot_r.erases;
  assign out_ch.invalidations_total = out_tot_r.invals;

  // ---- assertions ----
  // a request held back by a full result register keeps its write-back pending
  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && out_valid_r && !out_ch.ready |=> state_r == S_EXEC)
    else $error("request left EXEC while result register was blocked");

  // no request is taken in the cycle after a transfer (write-back interlock)
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("request accepted during write-back");

  // a result is never both a read hit and a refused write
  a_hit_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ch.page_hit && out_ch.write_refused))
    else $error("hit and refusal in one result");

  // a miss always reports all ones
  a_miss_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.page_hit |-> out_ch.read_tag == '1)
    else $error("miss without all-ones tag");

  // valid page count stays within a block's page count
  a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_ch.block_valid_pages <= npst_pkg::VCNT_W'(PG_USED))
    else $error("valid page count beyond block size");

endmodule

/* src/npst_block_store.sv */
// npst_block_store: one row per block (page conditions plus counts), with
// per-row valid bits so an unwritten row reads as all zero. No dependencies.
module npst_block_store #(
  parameter int DEPTH = 256,
  parameter int ROW_W = 167,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_row,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_row
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written row: all pages free, counts zero
  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

/* src/npst_tag_store.sv */
// npst_tag_store: sector tag memory, one entry per page, registered read.
// Depends on npst_pkg for the tag width.
module npst_tag_store #(
  parameter int DEPTH = 16384,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [npst_pkg::TAG_W-1:0] rd_tag,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [npst_pkg::TAG_W-1:0] wr_tag
);

  logic [npst_pkg::TAG_W-1:0] mem [DEPTH];
  logic [npst_pkg::TAG_W-1:0] rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      rd_tag_r <= mem[rd_addr];
    end
  end

  assign rd_tag = rd_tag_r;

endmodule

/* src/npst_stats.sv */
// npst_stats: the four global request counters, wrapping at 2^64.
// Depends on npst_pkg for stat_inc_t and stat_tot_t.
module npst_stats (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  npst_pkg::stat_inc_t  inc,
  output npst_pkg::stat_tot_t  tot_nxt
);

  npst_pkg::stat_tot_t tot_r;

  always_comb begin
    tot_nxt        = tot_r;
    tot_nxt.reads  = tot_r.reads  + npst_pkg::TOT_W'(inc.rd);
    tot_nxt.writes = tot_r.writes + npst_pkg::TOT_W'(inc.wr);
    tot_nxt.erases = tot_r.erases + npst_pkg::TOT_W'(inc.er);
    tot_nxt.invals = tot_r.invals + npst_pkg::TOT_W'(inc.inv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else if (upd) begin
      tot_r <= tot_nxt;
    end
  end

endmodule
